[sv/rrss_pkg.sv]
// Shared types and codes for the round-robin slot scheduler.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package rrss_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int TICK_W      = 9;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_ALLOC = 2'd1;
   localparam logic [1:0] MODE_KILL  = 2'd2;
   localparam logic [1:0] MODE_START = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SWITCHING_ENABLE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLICE_LENGTH     = 8'd1;

   localparam logic [TICK_W-1:0] TICK_MAX = 9'd511;

   typedef struct packed {
      logic [1:0] mode;
      logic [3:0] slot_id;
   } req_type;

   typedef struct packed {
      logic [3:0] current_slot;
      logic       switched;
      logic [3:0] new_slot;
      logic       no_free_slot;
      logic       all_stopped;
      logic [4:0] running_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SCAN,
      ST_APPLY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_req;
      logic update;
      logic scan;
      logic apply;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } status_type;

endpackage

[sv/round_robin_slot_scheduler_core.sv]
// Top level of the round-robin slot scheduler: sequencer plus datapath.
// Depends on rrss_pkg, rrss_ctrl and rrss_datapath.
`timescale 1ns / 1ps

// Usage
//   req_*  : one beat per request (mode, slot_id): tick, allocate the lowest
//            free slot, kill the current slot then tick, or start slot_id.
//   rsp_*  : one beat per request with the current slot, switch flag,
//            allocated slot, no-free and all-stopped flags and running count.
//   csr_*  : register writes (index 0 switching enable, 1 slice length);
//            csr_ready is always high. Write only while the block is idle.
// Timing
//   One request is in flight at a time. The slot scanner visits one slot
//   per cycle; each request passes through the update, scan, apply and
//   done states before rsp_valid, and the next request is taken once the
//   sequencer is back in the idle state.
//   The response register lets req_ready rise again while a result waits;
//   a stalled rsp_ready holds the finished beat and the next request waits
//   in the done state until the register frees up.
// Reset
//   Synchronous, active high: slot 0 running and current, slice counter
//   zero, switching enabled, slice length zero, no response pending.

module round_robin_slot_scheduler_core
   import rrss_pkg::*;
#(
   parameter int SLOT_COUNT = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   cmd_type    cmd;
   status_type status;

   // register writes never stall
   assign csr_ready = 1'b1;

   rrss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rrss_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // a taken request blocks the next one while it is worked on
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // the sequencer issues one command at a time
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command in a cycle");

   // a loaded response beat is presented next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("response loaded but not presented");

   // after the apply step the response is loaded or the sequencer is still busy
   assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> cmd.load_rsp || !req_ready)
      else $error("apply step not followed by the done state");
`endif

endmodule

[sv/rrss_ctrl.sv]
// Sequencer for the slot scheduler: walks each request through update,
// slot scan, apply and response load. Depends on rrss_pkg.
`timescale 1ns / 1ps

module rrss_ctrl
   import rrss_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_SCAN;
         ST_SCAN:   if (status.scan_last) state_in = ST_APPLY;
         ST_APPLY:  state_in = ST_DONE;
         ST_DONE:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_UPDATE: cmd.update = 1'b1;
         ST_SCAN:   cmd.scan   = 1'b1;
         ST_APPLY:  cmd.apply  = 1'b1;
         ST_DONE:   cmd.load_rsp = rsp_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/rrss_datapath.sv]
// Scheduler state, configuration registers, slot scanner and response
// register. Driven by commands from rrss_ctrl; depends on rrss_pkg.
`timescale 1ns / 1ps

module rrss_datapath
   import rrss_pkg::*;
#(
   parameter int SLOT_COUNT = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  req_type                req_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data,
   output rsp_type                rsp_data
);

   localparam int SW = $clog2(SLOT_COUNT);
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

   logic                  en_ff;
   logic [7:0]            slice_ff;
   logic [1:0]            mode_ff;
   logic [3:0]            sid_ff;
   logic [SLOT_COUNT-1:0] running_ff, running_in;
   logic [SW-1:0]         active_ff, active_in;
   logic [SW-1:0]         prev_ff;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [SW-1:0]         scan_ff;
   logic                  have_run_ff, have_second_ff, have_above_ff, have_free_ff;
   logic [SW-1:0]         first_run_ff, second_ff, above_ff, free_ff;
   logic [SW-1:0]         new_slot_ff, new_slot_in;
   logic                  no_free_ff, no_free_in;
   rsp_type               rsp_ff;

   logic                  tick_mode;
   logic                  scan_bit;
   logic                  moved;
   logic                  expire;
   logic [SW-1:0]         moved_slot;
   logic [SLOT_COUNT-1:0] start_mask;
   logic [SW+3:0]         active_wide, new_wide;
   logic [CW+4:0]         count_wide;

   assign tick_mode = (mode_ff == MODE_TICK) || (mode_ff == MODE_KILL);
   assign scan_bit  = running_ff[scan_ff];
   assign status.scan_last = (scan_ff == LAST_SLOT);

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff    <= 1'b1;
         slice_ff <= 8'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SWITCHING_ENABLE: en_ff    <= csr_data[0];
            CSR_SLICE_LENGTH:     slice_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      start_mask = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         start_mask[i] = (32'(sid_ff) == i);
      end
   end

   always_comb begin
      moved      = !running_ff[active_ff] && have_run_ff;
      moved_slot = moved ? first_run_ff : active_ff;
      expire     = (tick_ff > {1'b0, slice_ff}) && en_ff;
   end

   always_comb begin
      running_in  = running_ff;
      active_in   = active_ff;
      tick_in     = tick_ff;
      count_in    = count_ff;
      new_slot_in = new_slot_ff;
      no_free_in  = no_free_ff;
      if (cmd.update) begin
         // kill stops the current slot before the scan; start marks slot_id
         case (mode_ff)
            MODE_KILL:  running_in[active_ff] = 1'b0;
            MODE_START: running_in = running_ff | start_mask;
            default: ;
         endcase
         count_in    = '0;
         new_slot_in = '0;
         no_free_in  = 1'b0;
      end else if (cmd.scan) begin
         count_in = count_ff + CW'(scan_bit);
      end else if (cmd.apply) begin
         if (tick_mode) begin
            active_in = moved_slot;
            if (expire) begin
               if (count_ff > CW'(1)) begin
                  if (moved) begin
                     active_in = second_ff;
                  end else if (have_above_ff) begin
                     active_in = above_ff;
                  end else begin
                     active_in = first_run_ff;
                  end
               end
               tick_in = TICK_W'(1);
            end else if (tick_ff < TICK_MAX) begin
               tick_in = tick_ff + TICK_W'(1);
            end
         end else if (mode_ff == MODE_ALLOC) begin
            if (have_free_ff) begin
               running_in[free_ff] = 1'b1;
               new_slot_in         = free_ff;
               count_in            = count_ff + CW'(1);
            end else begin
               no_free_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= SLOT_COUNT'(1);
         active_ff  <= '0;
         tick_ff    <= '0;
      end else begin
         running_ff <= running_in;
         active_ff  <= active_in;
         tick_ff    <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      new_slot_ff <= new_slot_in;
      no_free_ff  <= no_free_in;
      if (cmd.load_req) begin
         mode_ff <= req_data.mode;
         sid_ff  <= req_data.slot_id;
         prev_ff <= active_ff;
      end
   end

   // one slot per cycle: count, two lowest running, next running above
   // the current slot, lowest free
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         scan_ff        <= '0;
         have_run_ff    <= 1'b0;
         have_second_ff <= 1'b0;
         have_above_ff  <= 1'b0;
         have_free_ff   <= 1'b0;
      end else if (cmd.scan) begin
         if (!status.scan_last) begin
            scan_ff <= scan_ff + SW'(1);
         end
         if (scan_bit && !have_run_ff) begin
            have_run_ff  <= 1'b1;
            first_run_ff <= scan_ff;
         end else if (scan_bit && !have_second_ff) begin
            have_second_ff <= 1'b1;
            second_ff      <= scan_ff;
         end
         if (scan_bit && (scan_ff > active_ff) && !have_above_ff) begin
            have_above_ff <= 1'b1;
            above_ff      <= scan_ff;
         end
         if (!scan_bit && !have_free_ff) begin
            have_free_ff <= 1'b1;
            free_ff      <= scan_ff;
         end
      end
   end

   assign active_wide = {4'b0, active_ff};
   assign new_wide    = {4'b0, new_slot_ff};
   assign count_wide  = {5'b0, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.current_slot  <= active_wide[3:0];
         rsp_ff.switched      <= (active_ff != prev_ff);
         rsp_ff.new_slot      <= new_wide[3:0];
         rsp_ff.no_free_slot  <= no_free_ff;
         rsp_ff.all_stopped   <= tick_mode && (count_ff == '0);
         rsp_ff.running_count <= count_wide[4:0];
      end
   end

   assign rsp_data = rsp_ff;

endmodule
